### hdl/ctp_pkg.sv
// Package for the call tree time profiler: transaction types, sequencer states,
// status codes and reset constants. No dependencies.
package ctp_pkg;

   // Default sizing of the call tree.
   localparam int NODE_COUNT_DEF        = 64;
   localparam int CHILDREN_PER_NODE_DEF = 8;

   // Reset value of the fine ticks per coarse tick register.
   localparam logic [31:0] FINE_TICKS_RESET = 32'd10000;

   // Event kinds.
   localparam logic KIND_ENTER = 1'b0;
   localparam logic KIND_EXIT  = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
   localparam logic [1:0] STATUS_CHILD_FULL = 2'd2;
   localparam logic [1:0] STATUS_EXIT_ROOT  = 2'd3;

   // One input event.
   typedef struct packed {
      logic        kind;
      logic [15:0] func_id;
      logic [31:0] tick_coarse;
      logic [31:0] tick_fine;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [5:0]  charged_node;
      logic [31:0] time_added;
      logic [31:0] charged_total;
      logic [5:0]  new_node;
      logic [1:0]  status;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_SUM1,
      ST_SUM2,
      ST_FIX,
      ST_TOTAL,
      ST_RD_CHILD,
      ST_RD_FUNC,
      ST_CMP,
      ST_MISS,
      ST_ALLOC,
      ST_ALLOC2,
      ST_FINISH
   } state_type;

endpackage

### hdl/call_tree_time_profiler.sv
// Top level of the call tree time profiler: sequencer, shared adder, multiplier
// and the node memories. Depends on ctp_pkg.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  ctp_pkg::req_type (enter/exit event)
// rsp      out        rsp_valid / rsp_ready  ctp_pkg::rsp_type (charge result)
// csr      in         csr_valid / csr_ready  32-bit fine ticks per coarse tick
//
// An exit steps from acceptance through DIFF, MUL, SUM1, SUM2, TOTAL and FINISH
// back to IDLE. An enter adds FIX after SUM2 and, after TOTAL, the states RD_CHILD,
// RD_FUNC and CMP for each child slot compared (child index read, function id read,
// compare), then MISS when no child matches and ALLOC, ALLOC2 when a node is allocated.
// Reset is synchronous; no clearing pass runs, both inputs are ready once it is released.
// A result waiting on rsp_ready holds the sequencer in its last state.
module call_tree_time_profiler #(
   parameter int NODE_COUNT        = ctp_pkg::NODE_COUNT_DEF,
   parameter int CHILDREN_PER_NODE = ctp_pkg::CHILDREN_PER_NODE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int NW  = $clog2(NODE_COUNT);
   localparam int UW  = $clog2(NODE_COUNT + 1);
   localparam int CW  = $clog2(CHILDREN_PER_NODE + 1);
   localparam int CD  = NODE_COUNT * CHILDREN_PER_NODE;
   localparam int CAW = $clog2(CD);

   // Node memories.
   logic [31:0]   total_mem [NODE_COUNT];
   logic [NW-1:0] parent_mem [NODE_COUNT];
   logic [CW-1:0] count_mem [NODE_COUNT];
   logic [NW-1:0] child_mem [CD];
   logic [15:0]   func_mem [NODE_COUNT];

   logic [31:0]   total_q_ff;
   logic [NW-1:0] parent_q_ff;
   logic [CW-1:0] count_q_ff;
   logic [NW-1:0] child_q_ff;
   logic [15:0]   func_q_ff;

   // Control registers.
   ctp_pkg::state_type state_ff, state_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [UW-1:0] nodes_used_ff, nodes_used_in;
   logic [CW-1:0] slot_ff, slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          root_tot_ok_ff, root_tot_ok_in;
   logic          root_cnt_ok_ff, root_cnt_ok_in;
   logic [31:0]   ftpc_ff, ftpc_in;
   logic [31:0]   last_coarse_ff, last_coarse_in;
   logic [31:0]   last_fine_ff, last_fine_in;

   // Payload registers.
   ctp_pkg::req_type req_ff, req_in;
   ctp_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   tot_ff, tot_in;
   logic [NW-1:0] new_ff, new_in;
   logic [1:0]    status_ff, status_in;

   // Shared adder and memory ports.
   logic [31:0]    add_a, add_b, add_sum;
   logic           add_cin;
   logic           total_we, count_we, child_we, node_we;
   logic [NW-1:0]  total_waddr, count_waddr;
   logic [31:0]    total_wdata;
   logic [CW-1:0]  count_wdata;
   logic [CAW-1:0] child_base, child_raddr, child_waddr;
   logic [31:0]    total_cur;
   logic [CW-1:0]  cnt_cur;
   logic [CW-1:0]  slot_next;
   logic [NW-1:0]  alloc_node;

   assign req_ready = (state_ff == ctp_pkg::ST_IDLE) && !reset;
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Addressing of the child slots of the current node.
   assign child_base  = CAW'(cur_ff) * CAW'(CHILDREN_PER_NODE);
   assign child_raddr = child_base + CAW'(slot_ff);
   assign child_waddr = child_base + CAW'(cnt_cur);
   assign alloc_node  = nodes_used_ff[NW-1:0];
   assign slot_next   = slot_ff + CW'(1);

   // The root entries read as zero until they are first written.
   assign total_cur = (cur_ff == '0 && !root_tot_ok_ff) ? 32'd0 : total_q_ff;
   assign cnt_cur   = (cur_ff == '0 && !root_cnt_ok_ff) ? '0 : count_q_ff;

   assign add_sum = add_a + add_b + {31'd0, add_cin};

   // Next state, adder operand selection and memory writes.
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      nodes_used_in  = nodes_used_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff;
      root_tot_ok_in = root_tot_ok_ff;
      root_cnt_ok_in = root_cnt_ok_ff;
      ftpc_in        = ftpc_ff;
      last_coarse_in = last_coarse_ff;
      last_fine_in   = last_fine_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      acc_in         = acc_ff;
      tot_in         = tot_ff;
      new_in         = new_ff;
      status_in      = status_ff;
      add_a          = acc_ff;
      add_b          = 32'd0;
      add_cin        = 1'b0;
      total_we       = 1'b0;
      total_waddr    = cur_ff;
      total_wdata    = add_sum;
      count_we       = 1'b0;
      count_waddr    = cur_ff;
      count_wdata    = cnt_cur + CW'(1);
      child_we       = 1'b0;
      node_we        = 1'b0;

      if (csr_valid && csr_ready) begin
         ftpc_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ctp_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ctp_pkg::ST_DIFF;
            end
         end
         ctp_pkg::ST_DIFF: begin
            add_a    = req_ff.tick_coarse;
            add_b    = ~last_coarse_ff;
            add_cin  = 1'b1;
            acc_in   = add_sum;
            state_in = ctp_pkg::ST_MUL;
         end
         ctp_pkg::ST_MUL: begin
            acc_in   = acc_ff * ftpc_ff;
            state_in = ctp_pkg::ST_SUM1;
         end
         ctp_pkg::ST_SUM1: begin
            add_b    = req_ff.tick_fine;
            acc_in   = add_sum;
            state_in = ctp_pkg::ST_SUM2;
         end
         ctp_pkg::ST_SUM2: begin
            add_b    = ~last_fine_ff;
            add_cin  = 1'b1;
            acc_in   = add_sum;
            state_in = (req_ff.kind == ctp_pkg::KIND_ENTER) ? ctp_pkg::ST_FIX
                                                            : ctp_pkg::ST_TOTAL;
         end
         ctp_pkg::ST_FIX: begin
            // A negative elapsed time on enter gets one period added.
            add_b = ftpc_ff;
            if (acc_ff[31]) begin
               acc_in = add_sum;
            end
            state_in = ctp_pkg::ST_TOTAL;
         end
         ctp_pkg::ST_TOTAL: begin
            add_a          = total_cur;
            add_b          = acc_ff;
            total_we       = 1'b1;
            tot_in         = add_sum;
            last_coarse_in = req_ff.tick_coarse;
            last_fine_in   = req_ff.tick_fine;
            slot_in        = '0;
            status_in      = ctp_pkg::STATUS_OK;
            new_in         = cur_ff;
            if (cur_ff == '0) begin
               root_tot_ok_in = 1'b1;
            end
            if (req_ff.kind == ctp_pkg::KIND_EXIT) begin
               if (cur_ff == '0) begin
                  status_in = ctp_pkg::STATUS_EXIT_ROOT;
               end else begin
                  new_in = parent_q_ff;
               end
               state_in = ctp_pkg::ST_FINISH;
            end else if (cnt_cur == '0) begin
               state_in = ctp_pkg::ST_MISS;
            end else begin
               state_in = ctp_pkg::ST_RD_CHILD;
            end
         end
         ctp_pkg::ST_RD_CHILD: begin
            state_in = ctp_pkg::ST_RD_FUNC;
         end
         ctp_pkg::ST_RD_FUNC: begin
            state_in = ctp_pkg::ST_CMP;
         end
         ctp_pkg::ST_CMP: begin
            // Compare one child's function id; on a mismatch step to the next slot.
            if (func_q_ff == req_ff.func_id) begin
               new_in   = child_q_ff;
               state_in = ctp_pkg::ST_FINISH;
            end else begin
               slot_in  = slot_next;
               state_in = (slot_next == cnt_cur) ? ctp_pkg::ST_MISS
                                                 : ctp_pkg::ST_RD_CHILD;
            end
         end
         ctp_pkg::ST_MISS: begin
            if (nodes_used_ff >= UW'(NODE_COUNT)) begin
               status_in = ctp_pkg::STATUS_TABLE_FULL;
               state_in  = ctp_pkg::ST_FINISH;
            end else if (cnt_cur >= CW'(CHILDREN_PER_NODE)) begin
               status_in = ctp_pkg::STATUS_CHILD_FULL;
               state_in  = ctp_pkg::ST_FINISH;
            end else begin
               state_in = ctp_pkg::ST_ALLOC;
            end
         end
         ctp_pkg::ST_ALLOC: begin
            // Link the new node below the current one and clear its total.
            child_we    = 1'b1;
            node_we     = 1'b1;
            count_we    = 1'b1;
            total_we    = 1'b1;
            total_waddr = alloc_node;
            total_wdata = 32'd0;
            if (cur_ff == '0) begin
               root_cnt_ok_in = 1'b1;
            end
            state_in = ctp_pkg::ST_ALLOC2;
         end
         ctp_pkg::ST_ALLOC2: begin
            count_we      = 1'b1;
            count_waddr   = alloc_node;
            count_wdata   = '0;
            nodes_used_in = nodes_used_ff + UW'(1);
            new_in        = alloc_node;
            state_in      = ctp_pkg::ST_FINISH;
         end
         ctp_pkg::ST_FINISH: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.charged_node  = 6'(cur_ff);
               rsp_in.time_added    = acc_ff;
               rsp_in.charged_total = tot_ff;
               rsp_in.new_node      = 6'(new_ff);
               rsp_in.status        = status_ff;
               cur_in               = new_ff;
               state_in             = ctp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ctp_pkg::ST_IDLE;
         cur_ff         <= '0;
         nodes_used_ff  <= UW'(1);
         slot_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         root_tot_ok_ff <= 1'b0;
         root_cnt_ok_ff <= 1'b0;
         ftpc_ff        <= ctp_pkg::FINE_TICKS_RESET;
         last_coarse_ff <= 32'd0;
         last_fine_ff   <= 32'd0;
      end else begin
         state_ff       <= state_in;
         cur_ff         <= cur_in;
         nodes_used_ff  <= nodes_used_in;
         slot_ff        <= slot_in;
         rsp_valid_ff   <= rsp_valid_in;
         root_tot_ok_ff <= root_tot_ok_in;
         root_cnt_ok_ff <= root_cnt_ok_in;
         ftpc_ff        <= ftpc_in;
         last_coarse_ff <= last_coarse_in;
         last_fine_ff   <= last_fine_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      acc_ff    <= acc_in;
      tot_ff    <= tot_in;
      new_ff    <= new_in;
      status_ff <= status_in;
   end

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (total_we) begin
         total_mem[total_waddr] <= total_wdata;
      end
      if (count_we) begin
         count_mem[count_waddr] <= count_wdata;
      end
      if (child_we) begin
         child_mem[child_waddr] <= alloc_node;
      end
      if (node_we) begin
         parent_mem[alloc_node] <= cur_ff;
         func_mem[alloc_node]   <= req_ff.func_id;
      end
      total_q_ff  <= total_mem[cur_ff];
      count_q_ff  <= count_mem[cur_ff];
      parent_q_ff <= parent_mem[cur_ff];
      child_q_ff  <= child_mem[child_raddr];
      func_q_ff   <= func_mem[child_q_ff];
   end

   // The current node is always one that has been allocated.
   assert property (@(posedge clock) disable iff (reset)
      UW'(cur_ff) < nodes_used_ff)
      else $error("current node beyond allocated nodes");

   // A result appears only when the sequencer finishes an event.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == ctp_pkg::ST_FINISH))
      else $error("result raised outside finish state");

   // The node count grows only by an allocation.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && nodes_used_ff != $past(nodes_used_ff)
      |-> $past(state_ff == ctp_pkg::ST_ALLOC2))
      else $error("node count changed outside allocation");

   // The child search stays within the current node's children.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ctp_pkg::ST_CMP |-> slot_ff < cnt_cur)
      else $error("child slot beyond child count");

endmodule
